>>> hw/rtl/ffba_pkg.sv
// Shared types and constants for the first-fit block allocator.
package ffba_pkg;

   // Fixed field widths
   localparam int ADDR_W = 32;
   localparam int SIZE_W = 24;

   // Reset value of the heap limit register
   localparam logic [ADDR_W-1:0] HEAP_LIMIT_RESET = 32'd1048576;

   // Operation codes
   localparam logic MODE_ALLOC = 1'b0;
   localparam logic MODE_FREE  = 1'b1;

   // Response status codes
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_ZERO    = 2'd1;
   localparam logic [1:0] STATUS_NOMEM   = 2'd2;
   localparam logic [1:0] STATUS_UNKNOWN = 2'd3;

   // Controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } ffba_state_type;

   // One block table entry
   typedef struct packed {
      logic [ADDR_W-1:0] base;
      logic [SIZE_W-1:0] size;
      logic              free;
   } ffba_entry_type;

   // Controller to datapath commands
   typedef struct packed {
      logic accept;
      logic scan;
      logic finish;
   } ffba_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic scan_done;
      logic out_free;
   } ffba_stat_type;

endpackage

>>> hw/rtl/ffba_ctrl.sv
// Controller state machine for the first-fit block allocator.
module ffba_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  ffba_pkg::ffba_stat_type stat_i,
   output ffba_pkg::ffba_cmd_type  cmd_o
);
   import ffba_pkg::*;

   ffba_state_type state_ff, state_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (stat_i.scan_done) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (stat_i.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      req_stall    = 1'b1;
      cmd_o        = '0;
      case (state_ff)
         ST_IDLE: begin
            req_stall    = 1'b0;
            cmd_o.accept = req_valid;
         end
         ST_SCAN: begin
            cmd_o.scan = 1'b1;
         end
         ST_FINISH: begin
            cmd_o.finish = stat_i.out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // A finished word always returns the controller to idle
   a_finish_to_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && stat_i.out_free) |=> state_ff == ST_IDLE)
      else $error("controller did not return to idle after finish");

endmodule

>>> hw/rtl/ffba_dp.sv
// Datapath of the first-fit block allocator: block table, scan pipeline, result register.
module ffba_dp #(
   parameter int MAX_BLOCKS   = 64,
   parameter int HEADER_BYTES = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  ffba_pkg::ffba_cmd_type        cmd_i,
   output ffba_pkg::ffba_stat_type       stat_o,
   input  logic                          req_mode,
   input  logic [ffba_pkg::SIZE_W-1:0]   req_request_size,
   input  logic [ffba_pkg::ADDR_W-1:0]   req_free_address,
   input  logic                          csr_write_en,
   input  logic [ffba_pkg::ADDR_W-1:0]   csr_write_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [ffba_pkg::ADDR_W-1:0]   rsp_data_address,
   output logic [1:0]                    rsp_status
);
   import ffba_pkg::*;

   localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
   localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam logic [CNT_W-1:0]  MAX_CNT = CNT_W'(MAX_BLOCKS);
   localparam logic [ADDR_W:0]   HDR_EXT = (ADDR_W + 1)'(HEADER_BYTES);
   localparam logic [ADDR_W+1:0] HDR_END = (ADDR_W + 2)'(HEADER_BYTES);

   // Block table
   ffba_entry_type mem [MAX_BLOCKS];

   // Latched request
   logic              mode_ff, mode_in;
   logic [SIZE_W-1:0] size_ff, size_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;

   // Scan pipeline
   logic [CNT_W-1:0]  scan_idx_ff, scan_idx_in;
   logic              rd_valid_ff, rd_valid_in;
   logic [IDX_W-1:0]  rd_idx_ff, rd_idx_in;
   ffba_entry_type    rd_data_ff;
   logic              hit_ff, hit_in;
   logic [IDX_W-1:0]  hit_idx_ff, hit_idx_in;
   ffba_entry_type    hit_entry_ff, hit_entry_in;

   // Allocator state and configuration
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [ADDR_W-1:0] top_ff, top_in;
   logic [ADDR_W-1:0] limit_ff, limit_in;

   // Result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0] rsp_addr_ff, rsp_addr_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;

   // Table write port
   logic              wr_en;
   logic [IDX_W-1:0]  wr_idx;
   ffba_entry_type    wr_entry;

   logic              issue;
   logic              zero_req;
   logic              match;
   logic [ADDR_W+1:0] end_sum;

   assign zero_req = (mode_ff == MODE_ALLOC) ? (size_ff == '0) : (addr_ff == '0);
   assign issue    = cmd_i.scan && (scan_idx_ff < count_ff);
   assign end_sum  = {2'b00, top_ff} + HDR_END + (ADDR_W + 2)'(size_ff);

   // Entry check on the registered read word
   always_comb begin
      if (mode_ff == MODE_ALLOC) begin
         match = rd_data_ff.free && (rd_data_ff.size >= size_ff);
      end else begin
         match = ({1'b0, rd_data_ff.base} + HDR_EXT) == {1'b0, addr_ff};
      end
   end

   assign stat_o.scan_done = zero_req || (rd_valid_ff && match) ||
                             (!rd_valid_ff && (scan_idx_ff >= count_ff));
   assign stat_o.out_free  = !rsp_valid_ff || !rsp_stall;

   // Request capture and scan sequencing
   always_comb begin
      mode_in      = mode_ff;
      size_in      = size_ff;
      addr_in      = addr_ff;
      scan_idx_in  = scan_idx_ff;
      rd_valid_in  = issue;
      rd_idx_in    = scan_idx_ff[IDX_W-1:0];
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      hit_entry_in = hit_entry_ff;
      if (cmd_i.accept) begin
         mode_in     = req_mode;
         size_in     = req_request_size;
         addr_in     = req_free_address;
         scan_idx_in = '0;
         rd_valid_in = 1'b0;
         hit_in      = 1'b0;
      end else if (cmd_i.scan) begin
         if (issue) scan_idx_in = scan_idx_ff + 1'b1;
         if (rd_valid_ff && match && !zero_req && !hit_ff) begin
            hit_in       = 1'b1;
            hit_idx_in   = rd_idx_ff;
            hit_entry_in = rd_data_ff;
         end
      end
   end

   // Result and table update
   always_comb begin
      count_in      = count_ff;
      top_in        = top_ff;
      limit_in      = csr_write_en ? csr_write_data : limit_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_addr_in   = rsp_addr_ff;
      rsp_status_in = rsp_status_ff;
      wr_en         = 1'b0;
      wr_idx        = hit_idx_ff;
      wr_entry      = hit_entry_ff;
      if (cmd_i.finish) begin
         rsp_valid_in  = 1'b1;
         rsp_addr_in   = '0;
         rsp_status_in = STATUS_OK;
         if (mode_ff == MODE_ALLOC) begin
            if (zero_req) begin
               rsp_status_in = STATUS_ZERO;
            end else if (hit_ff) begin
               wr_en         = 1'b1;
               wr_entry.free = 1'b0;
               rsp_addr_in   = hit_entry_ff.base + HDR_EXT[ADDR_W-1:0];
            end else if ((count_ff >= MAX_CNT) ||
                         (end_sum > {2'b00, limit_ff})) begin
               rsp_status_in = STATUS_NOMEM;
            end else begin
               wr_en          = 1'b1;
               wr_idx         = count_ff[IDX_W-1:0];
               wr_entry.base  = top_ff;
               wr_entry.size  = size_ff;
               wr_entry.free  = 1'b0;
               count_in       = count_ff + 1'b1;
               top_in         = end_sum[ADDR_W-1:0];
               rsp_addr_in    = top_ff + HDR_EXT[ADDR_W-1:0];
            end
         end else begin
            if (!zero_req) begin
               if (hit_ff) begin
                  wr_en         = 1'b1;
                  wr_entry.free = 1'b1;
               end else begin
                  rsp_status_in = STATUS_UNKNOWN;
               end
            end
         end
      end
   end

   // Block table memory with registered read
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_idx] <= wr_entry;
      rd_data_ff <= mem[scan_idx_ff[IDX_W-1:0]];
   end

   // Payload registers
   always_ff @(posedge clock) begin
      mode_ff      <= mode_in;
      size_ff      <= size_in;
      addr_ff      <= addr_in;
      rd_idx_ff    <= rd_idx_in;
      hit_idx_ff   <= hit_idx_in;
      hit_entry_ff <= hit_entry_in;
      rsp_addr_ff  <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_idx_ff  <= '0;
         rd_valid_ff  <= 1'b0;
         hit_ff       <= 1'b0;
         count_ff     <= '0;
         top_ff       <= '0;
         limit_ff     <= HEAP_LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         scan_idx_ff  <= scan_idx_in;
         rd_valid_ff  <= rd_valid_in;
         hit_ff       <= hit_in;
         count_ff     <= count_in;
         top_ff       <= top_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_data_address = rsp_addr_ff;
   assign rsp_status       = rsp_status_ff;

   // Table fill never passes its capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= MAX_CNT)
      else $error("block count beyond table capacity");

   // A new word is never loaded over one still stalled
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd_i.finish |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result register overwritten while stalled");

   // Heap top only grows
   a_top_grows: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> top_ff >= $past(top_ff))
      else $error("heap top moved backward");

endmodule

>>> hw/rtl/first_fit_block_allocator_top.sv
// From accept to rsp_valid, the scan reads table entries in order and the finish state loads the result;
// a hit, a zero-size word or a null free exits early. A stalled result adds its stall time.
// The single-port block table read, one entry per cycle, sets the scan time.
// A new request word is taken while a finished result still waits on rsp_stall.
// Reset (synchronous, active high) empties the table, zeroes heap top, sets heap limit to 1 MiB.
module first_fit_block_allocator_top #(
   parameter int MAX_BLOCKS   = 64,
   parameter int HEADER_BYTES = 24
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_mode,
   input  logic [ffba_pkg::SIZE_W-1:0] req_request_size,
   input  logic [ffba_pkg::ADDR_W-1:0] req_free_address,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [ffba_pkg::ADDR_W-1:0] rsp_data_address,
   output logic [1:0]                  rsp_status,
   input  logic                        csr_write_en,
   input  logic [ffba_pkg::ADDR_W-1:0] csr_write_data
);
   import ffba_pkg::*;

   ffba_cmd_type  cmd;
   ffba_stat_type stat;

   // Sequencer
   ffba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat_i    (stat),
      .cmd_o     (cmd)
   );

   // Table and result datapath
   ffba_dp #(
      .MAX_BLOCKS   (MAX_BLOCKS),
      .HEADER_BYTES (HEADER_BYTES)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd_i            (cmd),
      .stat_o           (stat),
      .req_mode         (req_mode),
      .req_request_size (req_request_size),
      .req_free_address (req_free_address),
      .csr_write_en     (csr_write_en),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data_address (rsp_data_address),
      .rsp_status       (rsp_status)
   );

endmodule

>>> tb/first_fit_block_allocator_top_tb.sv
// Self-checking testbench for the first-fit block allocator: directed and random words.
`timescale 1ns / 100ps

module first_fit_block_allocator_top_tb;
   import ffba_pkg::*;

   localparam int TB_MAX_BLOCKS   = 64;
   localparam int TB_HEADER_BYTES = 24;
   localparam int QUIET_LIMIT     = 2000;

   typedef struct packed {
      logic [ADDR_W-1:0] data_address;
      logic [1:0]        status;
   } alloc_reply_type;

   // Shadow of the block table plus the queue of replies still owed
   class allocator_scoreboard;
      logic [ADDR_W-1:0] limit_q;
      logic [ADDR_W-1:0] base_q [TB_MAX_BLOCKS];
      logic [SIZE_W-1:0] size_q [TB_MAX_BLOCKS];
      bit                free_q [TB_MAX_BLOCKS];
      int unsigned       count_q;
      logic [ADDR_W-1:0] top_q;
      alloc_reply_type   awaited_replies[$];
      int                failures;
      int                replies_checked;
      int                status_seen[4];

      function new();
         limit_q         = HEAP_LIMIT_RESET;
         count_q         = 0;
         top_q           = '0;
         failures        = 0;
         replies_checked = 0;
         foreach (status_seen[k]) status_seen[k] = 0;
      endfunction

      // First-fit scan, append at heap top on a miss; address match on free
      function alloc_reply_type predict_reply(logic mode, logic [SIZE_W-1:0] size,
                                              logic [ADDR_W-1:0] addr);
         alloc_reply_type r;
         logic [ADDR_W:0] heap_end;
         logic [ADDR_W:0] data_end;
         bit              found;
         r.data_address = '0;
         r.status       = STATUS_OK;
         found          = 1'b0;
         if (mode == MODE_ALLOC) begin
            if (size == '0) begin
               r.status = STATUS_ZERO;
            end else begin
               for (int i = 0; i < count_q && !found; i++) begin
                  if (free_q[i] && size_q[i] >= size) begin
                     free_q[i]      = 1'b0;
                     r.data_address = base_q[i] + TB_HEADER_BYTES;
                     found          = 1'b1;
                  end
               end
               if (!found) begin
                  heap_end = {1'b0, top_q} + TB_HEADER_BYTES + size;
                  if (count_q >= TB_MAX_BLOCKS || heap_end > {1'b0, limit_q}) begin
                     r.status = STATUS_NOMEM;
                  end else begin
                     base_q[count_q] = top_q;
                     size_q[count_q] = size;
                     free_q[count_q] = 1'b0;
                     r.data_address  = top_q + TB_HEADER_BYTES;
                     count_q++;
                     top_q = heap_end[ADDR_W-1:0];
                  end
               end
            end
         end else if (addr != '0) begin
            for (int i = 0; i < count_q && !found; i++) begin
               data_end = {1'b0, base_q[i]} + TB_HEADER_BYTES;
               if (data_end == {1'b0, addr}) begin
                  free_q[i] = 1'b1;
                  found     = 1'b1;
               end
            end
            if (!found) r.status = STATUS_UNKNOWN;
         end
         return r;
      endfunction

      function void take_request(logic mode, logic [SIZE_W-1:0] size,
                                 logic [ADDR_W-1:0] addr);
         awaited_replies.push_back(predict_reply(mode, size, addr));
      endfunction

      function void check_reply(logic [ADDR_W-1:0] addr, logic [1:0] status);
         alloc_reply_type want;
         replies_checked++;
         status_seen[status]++;
         if (awaited_replies.size() == 0) begin
            if (failures < 10)
               $display("reply %0d with none expected: addr 0x%08h status %0d",
                        replies_checked, addr, status);
            failures++;
         end else begin
            want = awaited_replies.pop_front();
            if (want.data_address !== addr || want.status !== status) begin
               if (failures < 10)
                  $display({"reply %0d mismatch: expected addr 0x%08h status %0d,",
                            " got addr 0x%08h status %0d"},
                           replies_checked, want.data_address, want.status, addr, status);
               failures++;
            end
         end
      endfunction
   endclass

   logic              clock            = 1'b0;
   logic              reset            = 1'b1;
   logic              req_valid        = 1'b0;
   logic              req_stall;
   logic              req_mode         = MODE_ALLOC;
   logic [SIZE_W-1:0] req_request_size = '0;
   logic [ADDR_W-1:0] req_free_address = '0;
   logic              rsp_valid;
   logic              rsp_stall        = 1'b0;
   logic [ADDR_W-1:0] rsp_data_address;
   logic [1:0]        rsp_status;
   logic              csr_write_en     = 1'b0;
   logic [ADDR_W-1:0] csr_write_data   = '0;

   allocator_scoreboard sb = new();
   int sender_gap_max = 6;
   int sink_stall_max = 6;
   int words_sent     = 0;
   int limit_writes   = 0;
   int peak_blocks    = 0;
   int quiet_cycles   = 0;

   first_fit_block_allocator_top #(
      .MAX_BLOCKS   (TB_MAX_BLOCKS),
      .HEADER_BYTES (TB_HEADER_BYTES)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_request_size (req_request_size),
      .req_free_address (req_free_address),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data_address (rsp_data_address),
      .rsp_status       (rsp_status),
      .csr_write_en     (csr_write_en),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Monitors: note accepted request words, check accepted reply words
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         sb.take_request(req_mode, req_request_size, req_free_address);
         if (sb.count_q > peak_blocks) peak_blocks = sb.count_q;
      end
      if (!reset && rsp_valid === 1'b1 && !rsp_stall)
         sb.check_reply(rsp_data_address, rsp_status);
   end

   // Watchdog: too long without any handshake ends the run
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid === 1'b1 && !rsp_stall))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles, %0d replies owed",
                  quiet_cycles, sb.awaited_replies.size());
         $display("tb: failure");
         $finish;
      end
   end

   // Reply side: random stall before taking each word
   initial begin
      int hold;
      forever begin
         hold = $urandom_range(0, sink_stall_max);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!(rsp_valid === 1'b1 && !rsp_stall));
      end
   end

   task automatic send_word(input logic mode, input logic [SIZE_W-1:0] size,
                            input logic [ADDR_W-1:0] addr);
      int gap;
      gap = $urandom_range(0, sender_gap_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_mode         <= mode;
      req_request_size <= size;
      req_free_address <= addr;
      do @(posedge clock); while (req_stall);
      words_sent++;
   endtask

   // Stop sending and wait for every owed reply
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.awaited_replies.size() != 0) @(posedge clock);
   endtask

   task automatic write_heap_limit(input logic [ADDR_W-1:0] value);
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en   <= 1'b0;
      sb.limit_q = value;
      limit_writes++;
   endtask

   // Live addresses on most frees, sizes reused or random, with zero, near-miss and noise words
   task automatic random_word();
      int                pick;
      int                slot;
      logic [SIZE_W-1:0] size;
      logic [ADDR_W-1:0] addr;
      size = SIZE_W'($urandom);
      addr = $urandom;
      slot = (sb.count_q > 0) ? $urandom_range(0, sb.count_q - 1) : 0;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         pick = $urandom_range(0, 99);
         if (pick < 5) begin
            size = '0;
         end else if (pick < 40 && sb.count_q > 0) begin
            size = sb.size_q[slot];
            case ($urandom_range(0, 2))
               1: if (size > 1) size = size - 1'b1;
               2: if (size != '1) size = size + 1'b1;
               default: ;
            endcase
         end else if (pick < 70) begin
            size = SIZE_W'($urandom_range(1, 256));
         end else if (pick < 88) begin
            size = SIZE_W'($urandom_range(1, 65535));
         end else if (pick >= 95) begin
            size = '1;
         end
         send_word(MODE_ALLOC, size, addr);
      end else begin
         pick = $urandom_range(0, 99);
         if (pick < 60 && sb.count_q > 0) begin
            addr = sb.base_q[slot] + TB_HEADER_BYTES;
         end else if (pick < 70) begin
            addr = '0;
         end else if (pick < 85 && sb.count_q > 0) begin
            addr = sb.base_q[slot] + TB_HEADER_BYTES;
            if ($urandom_range(0, 1)) addr = addr + 1;
            else addr = addr - 1;
         end
         send_word(MODE_FREE, size, addr);
      end
   endtask

   task automatic run_phase(input logic [ADDR_W-1:0] limit, input int words,
                            input int gap_max, input int stall_max);
      wait_idle();
      write_heap_limit(limit);
      sender_gap_max = gap_max;
      sink_stall_max = stall_max;
      repeat (words) random_word();
   endtask

   initial begin
      logic [ADDR_W-1:0] fill;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: zero size, null and unknown frees, reuse, double free
      send_word(MODE_ALLOC, '0, '1);
      send_word(MODE_FREE, '1, '0);
      send_word(MODE_FREE, '0, '1);
      send_word(MODE_ALLOC, SIZE_W'(1), '0);
      send_word(MODE_ALLOC, '1, '0);
      send_word(MODE_ALLOC, SIZE_W'(100), '0);
      send_word(MODE_FREE, '0, TB_HEADER_BYTES);
      send_word(MODE_FREE, '0, TB_HEADER_BYTES);
      send_word(MODE_FREE, '0, TB_HEADER_BYTES + 1);
      send_word(MODE_ALLOC, SIZE_W'(2), '0);
      send_word(MODE_ALLOC, SIZE_W'(1), '0);

      // Grow exactly to the heap limit, then one byte more
      wait_idle();
      fill = sb.limit_q - sb.top_q - TB_HEADER_BYTES;
      send_word(MODE_ALLOC, fill[SIZE_W-1:0], '0);
      send_word(MODE_ALLOC, SIZE_W'(1), '0);
      send_word(MODE_FREE, '0, 2 * TB_HEADER_BYTES + 1);

      // Limit below heap top: reuse still works, growth fails
      wait_idle();
      write_heap_limit('0);
      send_word(MODE_ALLOC, SIZE_W'(50), '0);
      send_word(MODE_ALLOC, SIZE_W'(1), '0);

      // Widest limit: largest requests grow the heap
      wait_idle();
      write_heap_limit('1);
      send_word(MODE_ALLOC, '1, '0);
      send_word(MODE_ALLOC, '1, '0);
      send_word(MODE_FREE, '1, 32'h8000_0000);

      // Random phases over several limit settings
      run_phase(sb.top_q + 8192, 150, 6, 6);
      run_phase('1, 150, 0, 0);
      run_phase($urandom, 150, 6, 6);
      run_phase(HEAP_LIMIT_RESET, 75, 6, 6);
      run_phase(HEAP_LIMIT_RESET, 75, 3, 6);

      wait_idle();
      repeat (TB_MAX_BLOCKS + 8) @(posedge clock);

      $display("run: %0d words, %0d ok, %0d zero-size, %0d out of memory, %0d unknown frees",
               words_sent, sb.status_seen[STATUS_OK], sb.status_seen[STATUS_ZERO],
               sb.status_seen[STATUS_NOMEM], sb.status_seen[STATUS_UNKNOWN]);
      $display("run: table peaked at %0d of %0d blocks, heap top 0x%08h, %0d limit writes",
               peak_blocks, TB_MAX_BLOCKS, sb.top_q, limit_writes);
      if (sb.failures == 0 && sb.awaited_replies.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
